// File: rtl/core/hrlm_pkg.sv
// ----------------------------------------------------------------------------
// hrlm_pkg
// Types, codes and method tables shared by the request-line matcher.
// ----------------------------------------------------------------------------
package hrlm_pkg;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_METHOD,
    PH_SPACE,
    PH_PATH,
    PH_TOKEN,
    PH_DONE
  } phase_t;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CHOICE_W   = 4;
  localparam int unsigned OFFSET_W   = 3;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned PROGRESS_W = 3;

  localparam logic [CHOICE_W-1:0] M_GET     = 4'd0;
  localparam logic [CHOICE_W-1:0] M_DELETE  = 4'd1;
  localparam logic [CHOICE_W-1:0] M_CONNECT = 4'd2;
  localparam logic [CHOICE_W-1:0] M_HEAD    = 4'd3;
  localparam logic [CHOICE_W-1:0] M_TRACE   = 4'd4;
  localparam logic [CHOICE_W-1:0] M_OPTIONS = 4'd5;
  localparam logic [CHOICE_W-1:0] M_PATCH   = 4'd6;
  localparam logic [CHOICE_W-1:0] M_POST    = 4'd7;
  localparam logic [CHOICE_W-1:0] M_PUT     = 4'd8;
  localparam logic [CHOICE_W-1:0] M_NONE    = 4'd15;
  localparam logic [CHOICE_W-1:0] M_LAST    = M_PUT;

  localparam logic [COUNT_W-1:0]    COUNT_MAX  = 4'd15;
  localparam logic [PROGRESS_W-1:0] TOKEN_FULL = 3'd4;
  localparam logic [PROGRESS_W-1:0] TOKEN_DEAD = 3'd5;
  localparam logic [COUNT_W-1:0]    LINE_MIN   = 4'd8;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

  localparam logic [31:0] VERSION_WORD = "HTTP";

  function automatic logic is_ws(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_eol(input logic [BYTE_W-1:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  // Method text, left aligned in seven character slots.
  function automatic logic [BYTE_W-1:0] method_char(input logic [CHOICE_W-1:0] choice,
                                                    input logic [OFFSET_W-1:0] offset);
    logic [55:0] text;
    unique case (choice)
      M_GET:     text = {"GET", 32'h0};
      M_DELETE:  text = {"DELETE", 8'h0};
      M_CONNECT: text = "CONNECT";
      M_HEAD:    text = {"HEAD", 24'h0};
      M_TRACE:   text = {"TRACE", 16'h0};
      M_OPTIONS: text = "OPTIONS";
      M_PATCH:   text = {"PATCH", 16'h0};
      M_POST:    text = {"POST", 24'h0};
      M_PUT:     text = {"PUT", 32'h0};
      default:   text = '0;
    endcase
    return text[55 - 8*offset -: 8];
  endfunction

  function automatic logic [COUNT_W-1:0] method_len(input logic [CHOICE_W-1:0] choice);
    unique case (choice)
      M_GET, M_PUT:                   return 4'd3;
      M_HEAD, M_POST:                 return 4'd4;
      M_TRACE, M_PATCH:               return 4'd5;
      M_DELETE:                       return 4'd6;
      M_CONNECT, M_OPTIONS:           return 4'd7;
      default:                        return 4'd0;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] version_char(input logic [1:0] idx);
    return VERSION_WORD[31 - 8*idx -: 8];
  endfunction

endpackage

// File: rtl/core/hrlm_byte_if.sv
// ----------------------------------------------------------------------------
// hrlm_byte_if
// Valid/ready channel carrying one payload byte and its end-of-payload mark.
// ----------------------------------------------------------------------------
interface hrlm_byte_if;
  logic                          valid;
  logic                          ready;
  logic [hrlm_pkg::BYTE_W-1:0]   data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/core/hrlm_verdict_if.sv
// ----------------------------------------------------------------------------
// hrlm_verdict_if
// Valid/ready channel carrying one request-line verdict.
// ----------------------------------------------------------------------------
interface hrlm_verdict_if;
  logic valid;
  logic ready;
  logic is_request;

  modport source (output valid, output is_request, input ready);
  modport sink   (input valid, input is_request, output ready);
endinterface

// File: rtl/core/http_request_line_matcher_core.sv
// ----------------------------------------------------------------------------
// http_request_line_matcher_core
// Byte-stream matcher that decides whether a payload opens with a request line.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries the payload one byte per request, first byte first, with
//   last_byte set on the final byte. For each payload, verdict carries one
//   request, is_request, in the cycle after the last byte is taken.
//   Bytes without last_byte produce nothing on verdict.
// Throughput: one byte per cycle unless a held verdict stalls. Each byte passes through one stage of
//   small compare logic (method table lookup, whitespace test, "HTTP" token
//   match) that updates the scan registers and, on the last byte, the verdict
//   register.
// Stall: the verdict register is the only buffer. byte_in.ready drops while a
//   verdict is held and verdict.ready is low; it stays high when the verdict
//   is being taken in the same cycle.
// Reset: rst (synchronous) empties the verdict register and returns the scan
//   to the start of a payload. After every last byte the scan returns to the
//   same start state, so payloads follow back to back.
// ----------------------------------------------------------------------------
module http_request_line_matcher_core (
  input  logic                  clk,
  input  logic                  rst,
  hrlm_byte_if.sink             byte_in,
  hrlm_verdict_if.source        verdict
);

  // Scan registers
  hrlm_pkg::phase_t                      phase, phase_next;
  logic [hrlm_pkg::CHOICE_W-1:0]         method_choice, method_choice_next;
  logic [hrlm_pkg::OFFSET_W-1:0]         method_offset, method_offset_next;
  logic [hrlm_pkg::COUNT_W-1:0]          byte_count, byte_count_next;
  logic [hrlm_pkg::PROGRESS_W-1:0]       token_progress, token_progress_next;
  logic                                  token_good, token_good_next;
  logic                                  line_end_seen, line_end_seen_next;
  logic                                  failed, failed_next;

  // Verdict register
  logic out_valid;
  logic out_is_request;
  logic verdict_ok;

  logic                              accept;
  logic [hrlm_pkg::BYTE_W-1:0]       c;
  logic [hrlm_pkg::OFFSET_W-1:0]     offset_inc;

  assign c          = byte_in.data_byte;
  assign offset_inc = method_offset + 3'd1;

  // Take a new byte unless a held verdict is stalled.
  assign byte_in.ready = !out_valid || verdict.ready;
  assign accept        = byte_in.valid && byte_in.ready;

  assign verdict.valid      = out_valid;
  assign verdict.is_request = out_is_request;

  // Next scan state for the byte on the input.
  always_comb begin
    phase_next          = phase;
    method_choice_next  = method_choice;
    method_offset_next  = method_offset;
    token_progress_next = token_progress;
    token_good_next     = token_good;
    line_end_seen_next  = line_end_seen;
    failed_next         = failed;
    byte_count_next     = (byte_count == hrlm_pkg::COUNT_MAX) ? byte_count
                                                              : byte_count + 4'd1;

    // Once a check fails the scan freezes until the last byte.
    if (!failed) begin
      unique case (phase)
        hrlm_pkg::PH_FIRST: begin
          // P is ambiguous: decide on the second letter.
          method_offset_next = 3'd1;
          phase_next         = hrlm_pkg::PH_METHOD;
          unique case (c)
            "P": begin
              method_offset_next = method_offset;
              phase_next         = hrlm_pkg::PH_SECOND;
            end
            "G":     method_choice_next = hrlm_pkg::M_GET;
            "D":     method_choice_next = hrlm_pkg::M_DELETE;
            "C":     method_choice_next = hrlm_pkg::M_CONNECT;
            "H":     method_choice_next = hrlm_pkg::M_HEAD;
            "T":     method_choice_next = hrlm_pkg::M_TRACE;
            "O":     method_choice_next = hrlm_pkg::M_OPTIONS;
            default: begin
              method_offset_next = method_offset;
              phase_next         = phase;
              failed_next        = 1'b1;
            end
          endcase
        end
        hrlm_pkg::PH_SECOND: begin
          method_offset_next = 3'd2;
          phase_next         = hrlm_pkg::PH_METHOD;
          unique case (c)
            "A":     method_choice_next = hrlm_pkg::M_PATCH;
            "O":     method_choice_next = hrlm_pkg::M_POST;
            "U":     method_choice_next = hrlm_pkg::M_PUT;
            default: begin
              method_offset_next = method_offset;
              phase_next         = phase;
              failed_next        = 1'b1;
            end
          endcase
        end
        hrlm_pkg::PH_METHOD: begin
          if (method_choice > hrlm_pkg::M_LAST ||
              c != hrlm_pkg::method_char(method_choice, method_offset)) begin
            failed_next = 1'b1;
          end else begin
            method_offset_next = offset_inc;
            if ({1'b0, offset_inc} >= hrlm_pkg::method_len(method_choice)) begin
              phase_next = hrlm_pkg::PH_SPACE;
            end
          end
        end
        hrlm_pkg::PH_SPACE: begin
          // Line end straight after the method is rejected.
          if (hrlm_pkg::is_eol(c) || !hrlm_pkg::is_ws(c)) begin
            failed_next = 1'b1;
          end else begin
            phase_next = hrlm_pkg::PH_PATH;
          end
        end
        hrlm_pkg::PH_PATH: begin
          if (method_choice != hrlm_pkg::M_CONNECT && c != hrlm_pkg::CH_SLASH) begin
            failed_next = 1'b1;
          end else begin
            // Path start byte is not part of the version token.
            token_progress_next = '0;
            token_good_next     = 1'b0;
            if (hrlm_pkg::is_eol(c)) begin
              line_end_seen_next = 1'b1;
              failed_next        = 1'b1;
              phase_next         = hrlm_pkg::PH_DONE;
            end else begin
              phase_next = hrlm_pkg::PH_TOKEN;
            end
          end
        end
        hrlm_pkg::PH_TOKEN: begin
          priority if (hrlm_pkg::is_eol(c)) begin
            line_end_seen_next = 1'b1;
            failed_next        = !token_good;
            phase_next         = hrlm_pkg::PH_DONE;
          end else if (hrlm_pkg::is_ws(c)) begin
            // Whitespace opens a new token.
            token_progress_next = '0;
            token_good_next     = 1'b0;
          end else if (token_progress < hrlm_pkg::TOKEN_FULL) begin
            if (c == hrlm_pkg::version_char(token_progress[1:0])) begin
              token_progress_next = token_progress + 3'd1;
              token_good_next     = (token_progress + 3'd1 == hrlm_pkg::TOKEN_FULL);
            end else begin
              token_progress_next = hrlm_pkg::TOKEN_DEAD;
            end
          end else begin
            token_progress_next = token_progress;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Verdict for a payload ending on the current byte.
  always_comb begin
    verdict_ok = !failed_next && line_end_seen_next &&
                 (method_choice_next <= hrlm_pkg::M_LAST) &&
                 (byte_count_next >= hrlm_pkg::method_len(method_choice_next) +
                                     hrlm_pkg::LINE_MIN);
  end

  // Advance the scan; return to the start state after each last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= hrlm_pkg::PH_FIRST;
      method_choice  <= hrlm_pkg::M_NONE;
      method_offset  <= '0;
      byte_count     <= '0;
      token_progress <= '0;
      token_good     <= 1'b0;
      line_end_seen  <= 1'b0;
      failed         <= 1'b0;
    end else if (accept) begin
      if (byte_in.last_byte) begin
        phase          <= hrlm_pkg::PH_FIRST;
        method_choice  <= hrlm_pkg::M_NONE;
        method_offset  <= '0;
        byte_count     <= '0;
        token_progress <= '0;
        token_good     <= 1'b0;
        line_end_seen  <= 1'b0;
        failed         <= 1'b0;
      end else begin
        phase          <= phase_next;
        method_choice  <= method_choice_next;
        method_offset  <= method_offset_next;
        byte_count     <= byte_count_next;
        token_progress <= token_progress_next;
        token_good     <= token_good_next;
        line_end_seen  <= line_end_seen_next;
        failed         <= failed_next;
      end
    end
  end

  // Hold the verdict until taken; load a new one on each last byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && byte_in.last_byte) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_in.last_byte) begin
      out_is_request <= verdict_ok;
    end
  end

  // Checks
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_in.last_byte) |=> out_valid)
    else $error("last byte taken without a verdict");

  a_last_restarts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_in.last_byte) |=>
      (phase == hrlm_pkg::PH_FIRST && byte_count == '0 && !failed))
    else $error("scan not restarted after last byte");

  a_token_good_full: assert property (@(posedge clk) disable iff (rst)
    token_good == (token_progress == hrlm_pkg::TOKEN_FULL))
    else $error("token flag out of step with progress");

  a_line_end_done: assert property (@(posedge clk) disable iff (rst)
    line_end_seen |-> (phase == hrlm_pkg::PH_DONE))
    else $error("line end seen outside done phase");

  a_method_known: assert property (@(posedge clk) disable iff (rst)
    (phase == hrlm_pkg::PH_METHOD) |-> (method_choice <= hrlm_pkg::M_LAST))
    else $error("method phase without a chosen method");

endmodule
